// File: rtl/mrq_pkg.sv
// Shared constants and operation codes for the message ring queue.
package mrq_pkg;

   // Number of ring slots; one slot always stays empty.
   localparam int MRQ_DEPTH = 16;
   localparam int MRQ_PTR_W = (MRQ_DEPTH > 1) ? $clog2(MRQ_DEPTH) : 1;
   // Width for counts and offset sums: wide enough for DEPTH and for a 4-bit offset.
   localparam int MRQ_CMP_W = ((MRQ_PTR_W > 4) ? MRQ_PTR_W : 4) + 1;

   // One stored message: length, seven data bytes and the opcode.
   localparam int MRQ_WORD_W = 68;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

endpackage

// File: rtl/mrq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/message_ring_queue.sv
// Top level of the message ring queue: control, pointers and the result register.
//
// A ring-buffer queue of short messages (opcode, seven data bytes, length).
// Each request transfer on the req_ channel carries one operation: push, pop
// or peek at an offset from the head. Every request yields exactly one result
// transfer on the rsp_ channel with a status bit, the message read (zero for
// a push or a failure) and the fill count after the operation.
// The queue holds at most MRQ_DEPTH-1 messages; the messages live in one
// synchronous RAM with a registered read.
// A push or a failed operation loads the result register straight from the
// request transfer; a successful pop or peek first reads the RAM, enters
// ST_READ and loads the result register once the RAM read has returned.
// Throughput: one push or failed operation per cycle while rsp_stall is low;
// a successful pop or peek holds off requests in ST_READ, set by the single
// RAM read port. The next request is taken while a finished result is being taken.
// Reset empties the queue (both pointers to zero) and drops any pending
// result; stored messages are not cleared and are never read before written.
// While a result is valid and the receiver holds rsp_stall, the result stays
// unchanged and no new request is taken.
module message_ring_queue
   import mrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_data_a,
   input  logic [7:0] req_data_b,
   input  logic [7:0] req_data_c,
   input  logic [7:0] req_data_d,
   input  logic [7:0] req_data_e,
   input  logic [7:0] req_data_f,
   input  logic [7:0] req_data_g,
   input  logic [3:0] req_length,
   input  logic [3:0] req_peek_offset,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic [7:0] rsp_out_opcode,
   output logic [7:0] rsp_out_a,
   output logic [7:0] rsp_out_b,
   output logic [7:0] rsp_out_c,
   output logic [7:0] rsp_out_d,
   output logic [7:0] rsp_out_e,
   output logic [7:0] rsp_out_f,
   output logic [7:0] rsp_out_g,
   output logic [3:0] rsp_out_length,
   output logic [3:0] rsp_fill_count
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;

   logic [MRQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MRQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MRQ_CMP_W-1:0] pend_count_ff, pend_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [MRQ_WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [MRQ_CMP_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                  ram_we;
   logic                  ram_re;
   logic [MRQ_PTR_W-1:0]  ram_raddr;
   logic [MRQ_WORD_W-1:0] ram_wdata;
   logic [MRQ_WORD_W-1:0] ram_rdata;

   logic                  req_xfer;
   logic [MRQ_CMP_W-1:0]  held;
   logic [MRQ_CMP_W-1:0]  peek_sum;
   logic [MRQ_PTR_W-1:0]  peek_addr;
   logic [MRQ_PTR_W-1:0]  wr_ptr_next;
   logic [MRQ_PTR_W-1:0]  rd_ptr_next;
   logic                  full;
   logic                  empty;
   logic                  peek_ok;

   // Message storage.
   mrq_ram #(
      .WIDTH(MRQ_WORD_W),
      .DEPTH(MRQ_DEPTH),
      .ADDR_W(MRQ_PTR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_ptr_ff),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // A request is taken only when idle and when the result register is free
   // or is being emptied in this cycle.
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_xfer  = req_valid && !req_stall;

   assign ram_wdata = {req_length, req_data_g, req_data_f, req_data_e, req_data_d,
                       req_data_c, req_data_b, req_data_a, req_opcode};

   // Occupancy and wrapped pointer arithmetic.
   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         held = MRQ_CMP_W'(wr_ptr_ff) - MRQ_CMP_W'(rd_ptr_ff);
      end else begin
         held = MRQ_CMP_W'(wr_ptr_ff) + MRQ_CMP_W'(MRQ_DEPTH) - MRQ_CMP_W'(rd_ptr_ff);
      end
      wr_ptr_next = (wr_ptr_ff == MRQ_PTR_W'(MRQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_next = (rd_ptr_ff == MRQ_PTR_W'(MRQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      full  = (wr_ptr_next == rd_ptr_ff);
      empty = (wr_ptr_ff == rd_ptr_ff);
      // The offset is below the count on success, so one subtraction wraps it.
      peek_ok  = MRQ_CMP_W'(req_peek_offset) < held;
      peek_sum = MRQ_CMP_W'(rd_ptr_ff) + MRQ_CMP_W'(req_peek_offset);
      if (peek_sum >= MRQ_CMP_W'(MRQ_DEPTH)) begin
         peek_addr = MRQ_PTR_W'(peek_sum - MRQ_CMP_W'(MRQ_DEPTH));
      end else begin
         peek_addr = MRQ_PTR_W'(peek_sum);
      end
   end

   // Next-state logic: decode the request, drive the RAM, build the result.
   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_count_in = pend_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = rd_ptr_ff;

      unique case (state_ff)
         ST_READ: begin
            // The read data has arrived; the result register is free here.
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_word_in   = ram_rdata;
            rsp_count_in  = pend_count_ff;
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               // Failure is the default; successful cases override it.
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b1;
               rsp_word_in   = '0;
               rsp_count_in  = held;
               unique case (op_type'(req_op))
                  OP_PUSH: begin
                     if (!full) begin
                        ram_we        = 1'b1;
                        wr_ptr_in     = wr_ptr_next;
                        rsp_status_in = 1'b0;
                        rsp_count_in  = held + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (!empty) begin
                        ram_re        = 1'b1;
                        rd_ptr_in     = rd_ptr_next;
                        pend_count_in = held - 1'b1;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_READ;
                     end
                  end
                  OP_PEEK: begin
                     if (peek_ok) begin
                        ram_re        = 1'b1;
                        ram_raddr     = peek_addr;
                        pend_count_in = held;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_READ;
                     end
                  end
                  default: begin
                     // Unused operation code: nothing changes, result fails.
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, pointers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_count_ff <= pend_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Result outputs.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_opcode = rsp_word_ff[7:0];
   assign rsp_out_a      = rsp_word_ff[15:8];
   assign rsp_out_b      = rsp_word_ff[23:16];
   assign rsp_out_c      = rsp_word_ff[31:24];
   assign rsp_out_d      = rsp_word_ff[39:32];
   assign rsp_out_e      = rsp_word_ff[47:40];
   assign rsp_out_f      = rsp_word_ff[55:48];
   assign rsp_out_g      = rsp_word_ff[63:56];
   assign rsp_out_length = rsp_word_ff[67:64];
   assign rsp_fill_count = rsp_count_ff[3:0];

endmodule

// File: rtl/mrq_checker.sv
// Port-level checks for the message ring queue, bound to the top level.
module mrq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_status,
   input logic [7:0] rsp_out_opcode,
   input logic [7:0] rsp_out_a,
   input logic [7:0] rsp_out_g,
   input logic [3:0] rsp_out_length,
   input logic [3:0] rsp_fill_count
);

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // A failed operation carries an all-zero message.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_out_opcode == 8'd0 && rsp_out_a == 8'd0 && rsp_out_g == 8'd0 &&
          rsp_out_length == 4'd0))
      else $error("failed result carries a message");

   // A stalled result stays valid.
   a_stall_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its status and count.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_status) && $stable(rsp_fill_count)))
      else $error("result changed while stalled");

endmodule

bind message_ring_queue mrq_checker u_mrq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_opcode(rsp_out_opcode),
   .rsp_out_a     (rsp_out_a),
   .rsp_out_g     (rsp_out_g),
   .rsp_out_length(rsp_out_length),
   .rsp_fill_count(rsp_fill_count)
);
